// ===== design/mmh_pkg.sv =====
`default_nettype none

package mmh_pkg;

  // Mixing and reduction constants
  localparam logic [63:0] MIX_MULT       = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT      = 47;
  localparam logic [63:0] RED_MULT       = 64'h27d4eb2f165667c5;
  localparam logic [63:0] RED_ADD        = 64'h9e3779b97f4a7c15;
  localparam int unsigned RED_SHL        = 6;
  localparam int unsigned RED_SHR        = 2;
  localparam logic [63:0] SEED_LOW_RESET = 64'hc2b2ae3d27d4eb4f;
  localparam logic [63:0] SEED_HIGH_RESET = 64'h0;

  // Configuration register indexes
  localparam logic CFG_SEED_LOW  = 1'b0;
  localparam logic CFG_SEED_HIGH = 1'b1;

  // Bytes in one chunk
  localparam int unsigned CHUNK_BYTES = 16;

  // Partial products of a 128x64 multiply, mod 2^128: steps 0..6
  localparam logic [2:0] MUL_LAST_STEP = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEED,
    ST_SEED_W,
    ST_K1,
    ST_K1_W,
    ST_K2,
    ST_K2_W,
    ST_ACC,
    ST_ACC_W,
    ST_FIN,
    ST_FIN_W,
    ST_RED,
    ST_RED_W,
    ST_OUT
  } state_t;

  // Multiplier operand sources
  typedef enum logic [2:0] {
    XS_LEN,
    XS_CHUNK,
    XS_XSH_P,
    XS_ACC_XOR_P,
    XS_XSH_ACC,
    XS_HASH_HI
  } x_src_t;

  typedef enum logic {
    CS_MIX,
    CS_RED
  } c_sel_t;

  typedef struct packed {
    logic   item_load;
    logic   mul_start;
    x_src_t x_src;
    c_sel_t c_sel;
    logic   acc_seed;
    logic   acc_prod;
    logic   hash_load;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic has_bytes;
    logic mul_done;
    logic out_free;
  } dp_status_t;

  // v ^ (v >> 47) on 128 bits
  function automatic logic [127:0] xor_shift(input logic [127:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

  // 32-bit word of the 128-bit operand used at a multiply step
  function automatic logic [1:0] pp_x_word(input logic [2:0] step);
    logic [1:0] w;
    unique case (step)
      3'd0, 3'd1: w = 2'd0;
      3'd2, 3'd3: w = 2'd1;
      3'd4, 3'd5: w = 2'd2;
      3'd6:       w = 2'd3;
      default:    w = 2'd0;
    endcase
    return w;
  endfunction

  // 32-bit word of the 64-bit constant used at a multiply step
  function automatic logic pp_c_word(input logic [2:0] step);
    logic w;
    unique case (step)
      3'd1, 3'd3, 3'd5: w = 1'b1;
      default:          w = 1'b0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/mmh_mul.sv =====
`default_nettype none

// Sequential 128x64 multiply mod 2^128: one 32x32 partial product per cycle,
// registered, then added into the running sum the next cycle.
module mmh_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] x,
  input  logic [63:0]  c,
  output logic         done,
  output logic [127:0] prod
);

  logic         busy;
  logic [2:0]   cnt;
  logic [127:0] x_r;
  logic [63:0]  c_r;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [127:0] sum;

  logic [1:0]   xi;
  logic         cj;
  logic [31:0]  xw;
  logic [31:0]  cw;
  logic [63:0]  pp_next;
  logic [1:0]   pp_sh_next;

  // Operand word selection for this step
  always_comb begin
    xi         = mmh_pkg::pp_x_word(cnt);
    cj         = mmh_pkg::pp_c_word(cnt);
    xw         = x_r[{xi, 5'b0} +: 32];
    cw         = c_r[{cj, 5'b0} +: 32];
    pp_next    = xw * cw;
    pp_sh_next = xi + {1'b0, cj};
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == mmh_pkg::MUL_LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == mmh_pkg::MUL_LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Product register and accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      c_r <= c;
      sum <= '0;
    end else if (busy) begin
      if (cnt != mmh_pkg::MUL_LAST_STEP) begin
        pp    <= pp_next;
        pp_sh <= pp_sh_next;
      end
      if (cnt != 3'd0) begin
        sum <= sum + ({64'b0, pp} << {pp_sh, 5'b0});
      end
    end
  end

  assign prod = sum;

endmodule

`default_nettype wire

// ===== design/mmh_dp.sv =====
`default_nettype none

module mmh_dp #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [63:0]                cfg_data,
  input  logic [63:0]                chunk_low,
  input  logic [63:0]                chunk_high,
  input  logic [4:0]                 valid_bytes,
  input  logic [LENGTH_BITS-1:0]     total_length,
  input  logic                       first,
  input  logic                       last,
  input  mmh_pkg::dp_cmd_t           cmd,
  output mmh_pkg::dp_status_t        status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [63:0]                hash_low,
  output logic [63:0]                hash_high,
  output logic [63:0]                reduced
);

  logic [63:0]            seed_low;
  logic [63:0]            seed_high;
  logic [127:0]           chunk_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic                   first_r;
  logic                   last_r;
  logic                   has_bytes_r;
  logic [127:0]           acc;
  logic [127:0]           hash;

  logic [4:0]             nb_sat;
  logic [127:0]           byte_mask;
  logic [127:0]           mul_x;
  logic [63:0]            mul_c;
  logic                   mul_done;
  logic [127:0]           mul_p;
  logic [63:0]            red_sum;

  // Zero-pad past the valid byte count, counts above 16 taken as 16
  always_comb begin
    nb_sat = (valid_bytes > 5'(mmh_pkg::CHUNK_BYTES)) ? 5'(mmh_pkg::CHUNK_BYTES)
                                                      : valid_bytes;
    for (int b = 0; b < mmh_pkg::CHUNK_BYTES; b++) begin
      byte_mask[8*b +: 8] = (5'(b) < nb_sat) ? 8'hff : 8'h00;
    end
  end

  // Multiplier operand selection
  always_comb begin
    unique case (cmd.x_src)
      mmh_pkg::XS_LEN:       mul_x = 128'(len_r);
      mmh_pkg::XS_CHUNK:     mul_x = chunk_r;
      mmh_pkg::XS_XSH_P:     mul_x = mmh_pkg::xor_shift(mul_p);
      mmh_pkg::XS_ACC_XOR_P: mul_x = acc ^ mul_p;
      mmh_pkg::XS_XSH_ACC:   mul_x = mmh_pkg::xor_shift(acc);
      mmh_pkg::XS_HASH_HI:   mul_x = {64'b0, hash[127:64]};
      default:               mul_x = '0;
    endcase
    mul_c = (cmd.c_sel == mmh_pkg::CS_RED) ? mmh_pkg::RED_MULT : mmh_pkg::MIX_MULT;
  end

  mmh_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .x     (mul_x),
    .c     (mul_c),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // Seed registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_low  <= mmh_pkg::SEED_LOW_RESET;
      seed_high <= mmh_pkg::SEED_HIGH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == mmh_pkg::CFG_SEED_LOW) begin
        seed_low <= cfg_data;
      end else begin
        seed_high <= cfg_data;
      end
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      chunk_r     <= {chunk_high, chunk_low} & byte_mask;
      len_r       <= total_length;
      first_r     <= first;
      last_r      <= last;
      has_bytes_r <= (valid_bytes != 5'd0);
    end
  end

  // Accumulator and finished hash
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.acc_seed) begin
      acc <= {seed_high, seed_low} ^ mul_p;
    end else if (cmd.acc_prod) begin
      acc <= mul_p;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_load) begin
      hash <= mmh_pkg::xor_shift(mul_p);
    end
  end

  // Reduction: product low half holds hash_high * RED_MULT
  assign red_sum = mul_p[63:0] + mmh_pkg::RED_ADD
                 + (hash[63:0] << mmh_pkg::RED_SHL) + (hash[63:0] >> mmh_pkg::RED_SHR);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hash_low  <= hash[63:0];
      hash_high <= hash[127:64];
      reduced   <= hash[63:0] ^ red_sum;
    end
  end

  always_comb begin
    status.first     = first_r;
    status.last      = last_r;
    status.has_bytes = has_bytes_r;
    status.mul_done  = mul_done;
    status.out_free  = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== design/mmh_ctrl.sv =====
`default_nettype none

module mmh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mmh_pkg::dp_status_t status,
  output mmh_pkg::dp_cmd_t    cmd
);

  mmh_pkg::state_t state;
  mmh_pkg::state_t state_next;
  logic            in_message;
  logic            in_message_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mmh_pkg::ST_IDLE;
      in_message <= 1'b0;
    end else begin
      state      <= state_next;
      in_message <= in_message_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next      = state;
    in_message_next = in_message;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.x_src       = mmh_pkg::XS_LEN;
    cmd.c_sel       = mmh_pkg::CS_MIX;

    unique case (state)
      mmh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next    = mmh_pkg::ST_CHECK;
        end
      end
      mmh_pkg::ST_CHECK: begin
        priority if (status.first) begin
          in_message_next = 1'b1;
          state_next      = mmh_pkg::ST_SEED;
        end else if (!in_message) begin
          state_next = mmh_pkg::ST_IDLE;
        end else if (status.has_bytes) begin
          state_next = mmh_pkg::ST_K1;
        end else if (status.last) begin
          state_next = mmh_pkg::ST_FIN;
        end else begin
          state_next = mmh_pkg::ST_IDLE;
        end
      end
      // Seed ^ (length * M)
      mmh_pkg::ST_SEED: begin
        cmd.mul_start = 1'b1;
        cmd.x_src     = mmh_pkg::XS_LEN;
        state_next    = mmh_pkg::ST_SEED_W;
      end
      mmh_pkg::ST_SEED_W: begin
        if (status.mul_done) begin
          cmd.acc_seed = 1'b1;
          priority if (status.has_bytes) begin
            state_next = mmh_pkg::ST_K1;
          end else if (status.last) begin
            state_next = mmh_pkg::ST_FIN;
          end else begin
            state_next = mmh_pkg::ST_IDLE;
          end
        end
      end
      // k *= M
      mmh_pkg::ST_K1: begin
        cmd.mul_start = 1'b1;
        cmd.x_src     = mmh_pkg::XS_CHUNK;
        state_next    = mmh_pkg::ST_K1_W;
      end
      mmh_pkg::ST_K1_W: begin
        if (status.mul_done) begin
          state_next = mmh_pkg::ST_K2;
        end
      end
      // k ^= k >> 47; k *= M
      mmh_pkg::ST_K2: begin
        cmd.mul_start = 1'b1;
        cmd.x_src     = mmh_pkg::XS_XSH_P;
        state_next    = mmh_pkg::ST_K2_W;
      end
      mmh_pkg::ST_K2_W: begin
        if (status.mul_done) begin
          state_next = mmh_pkg::ST_ACC;
        end
      end
      // acc = (acc ^ k) * M
      mmh_pkg::ST_ACC: begin
        cmd.mul_start = 1'b1;
        cmd.x_src     = mmh_pkg::XS_ACC_XOR_P;
        state_next    = mmh_pkg::ST_ACC_W;
      end
      mmh_pkg::ST_ACC_W: begin
        if (status.mul_done) begin
          cmd.acc_prod = 1'b1;
          state_next   = status.last ? mmh_pkg::ST_FIN : mmh_pkg::ST_IDLE;
        end
      end
      // Finalization: xor-shift, multiply, xor-shift
      mmh_pkg::ST_FIN: begin
        cmd.mul_start = 1'b1;
        cmd.x_src     = mmh_pkg::XS_XSH_ACC;
        state_next    = mmh_pkg::ST_FIN_W;
      end
      mmh_pkg::ST_FIN_W: begin
        if (status.mul_done) begin
          cmd.hash_load = 1'b1;
          state_next    = mmh_pkg::ST_RED;
        end
      end
      // High half times the reduction multiplier
      mmh_pkg::ST_RED: begin
        cmd.mul_start = 1'b1;
        cmd.x_src     = mmh_pkg::XS_HASH_HI;
        cmd.c_sel     = mmh_pkg::CS_RED;
        state_next    = mmh_pkg::ST_RED_W;
      end
      mmh_pkg::ST_RED_W: begin
        if (status.mul_done) begin
          state_next = mmh_pkg::ST_OUT;
        end
      end
      // Wait for a free output register
      mmh_pkg::ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load    = 1'b1;
          in_message_next = 1'b0;
          state_next      = mmh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mmh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/murmur_style_block_hash_128_core.sv =====
// Streaming 128-bit block hash. Messages enter as 16-byte little-endian
// chunks on the in_valid/in_ready channel; the first chunk carries the total
// length, the last one closes the message and yields one result (128-bit
// hash plus 64-bit reduction) on the out_valid/out_ready channel.
// Seeds are written through cfg_we/cfg_index/cfg_data while idle; the user
// must keep to this, as the block itself does not enforce it. All multiplies
// run through one shared 32x32 multiplier: each 128x64 multiply takes 7
// partial products. A middle chunk with data needs 3 multiplies, a first adds
// 1, a last adds 2.
// The result sits in an output register; the block takes new requests while
// it waits, and only stalls on a further last chunk while that register is
// still full. Reset clears the open message, the output valid and restores
// the seed reset values.
`default_nettype none

module murmur_style_block_hash_128_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [63:0]            chunk_low,
  input  logic [63:0]            chunk_high,
  input  logic [4:0]             valid_bytes,
  input  logic [LENGTH_BITS-1:0] total_length,
  input  logic                   first,
  input  logic                   last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            hash_low,
  output logic [63:0]            hash_high,
  output logic [63:0]            reduced
);

  mmh_pkg::dp_cmd_t    cmd;
  mmh_pkg::dp_status_t status;

  mmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mmh_dp #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .chunk_low    (chunk_low),
    .chunk_high   (chunk_high),
    .valid_bytes  (valid_bytes),
    .total_length (total_length),
    .first        (first),
    .last         (last),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hash_low     (hash_low),
    .hash_high    (hash_high),
    .reduced      (reduced)
  );

endmodule

`default_nettype wire
